// ----- hw/rtl/ccc_pkg.sv -----
// Shared types and constants for the circle-circle collision test.
// Used by the front, queue, back and top-level modules; depends on nothing.
package ccc_pkg;

    localparam int NORM_BITS = 16;
    localparam int QUO_BITS  = 15;
    localparam int Q_DEPTH   = 4;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

// ----- hw/rtl/ccc_front.sv -----
// Front part: centre differences, squared distance, pipelined square root and depth test.
// Depends on ccc_pkg for the queue status type.
module ccc_front #(
    parameter int W = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [W-1:0]        i_self_x,
    input  logic [W-1:0]        i_self_z,
    input  logic [W-2:0]        i_self_radius,
    input  logic [W-1:0]        i_other_x,
    input  logic [W-1:0]        i_other_z,
    input  logic [W-2:0]        i_other_radius,
    input  ccc_pkg::t_q_stat    i_q_stat,
    output logic                o_push,
    output logic [7*W+1:0]      o_push_data
);

    localparam int MW = W + 1;
    localparam int H  = MW / 2;
    localparam int HB = MW - H;
    localparam int NW = 2 * W + 2;
    localparam int NS = W + 1;

    logic en;

    logic                r_a_vld;
    logic signed [W:0]   r_a_dx, r_a_dz;
    logic [W-1:0]        r_a_rsum, r_a_sx, r_a_sz;
    logic [W-2:0]        r_a_sr;

    logic                r_b_vld;
    logic [2*HB-1:0]     r_b_hh_x, r_b_hh_z;
    logic [MW-1:0]       r_b_hl_x, r_b_hl_z;
    logic [2*H-1:0]      r_b_ll_x, r_b_ll_z;
    logic signed [W:0]   r_b_dx, r_b_dz;
    logic [W-1:0]        r_b_rsum, r_b_sx, r_b_sz;
    logic [W-2:0]        r_b_sr;

    logic                r_s_vld  [0:NS];
    logic [NW-1:0]       r_s_rem  [0:NS];
    logic [W:0]          r_s_root [0:NS];
    logic signed [W:0]   r_s_dx   [0:NS];
    logic signed [W:0]   r_s_dz   [0:NS];
    logic [W-1:0]        r_s_rsum [0:NS];
    logic [W-1:0]        r_s_sx   [0:NS];
    logic [W-1:0]        r_s_sz   [0:NS];
    logic [W-2:0]        r_s_sr   [0:NS];

    logic signed [W:0]   n_dx, n_dz;
    logic [MW-1:0]       n_mx, n_mz;
    logic [W:0]          n_depth;
    logic                n_neg;

    assign en         = !r_s_vld[NS] || !i_q_stat.full;
    assign o_in_stall = !en;

    assign n_dx = $signed({i_other_x[W-1], i_other_x}) - $signed({i_self_x[W-1], i_self_x});
    assign n_dz = $signed({i_other_z[W-1], i_other_z}) - $signed({i_self_z[W-1], i_self_z});
    assign n_mx = r_a_dx[W] ? MW'(-r_a_dx) : MW'(r_a_dx);
    assign n_mz = r_a_dz[W] ? MW'(-r_a_dz) : MW'(r_a_dz);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld    <= 1'b0;
            r_b_vld    <= 1'b0;
            r_s_vld[0] <= 1'b0;
        end else if (en) begin
            r_a_vld    <= i_in_valid;
            r_b_vld    <= r_a_vld;
            r_s_vld[0] <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_dx   <= n_dx;
            r_a_dz   <= n_dz;
            r_a_rsum <= W'({1'b0, i_self_radius}) + W'({1'b0, i_other_radius});
            r_a_sx   <= i_self_x;
            r_a_sz   <= i_self_z;
            r_a_sr   <= i_self_radius;

            r_b_hh_x <= n_mx[MW-1:H] * n_mx[MW-1:H];
            r_b_hl_x <= MW'(n_mx[MW-1:H] * n_mx[H-1:0]);
            r_b_ll_x <= n_mx[H-1:0] * n_mx[H-1:0];
            r_b_hh_z <= n_mz[MW-1:H] * n_mz[MW-1:H];
            r_b_hl_z <= MW'(n_mz[MW-1:H] * n_mz[H-1:0]);
            r_b_ll_z <= n_mz[H-1:0] * n_mz[H-1:0];
            r_b_dx   <= r_a_dx;
            r_b_dz   <= r_a_dz;
            r_b_rsum <= r_a_rsum;
            r_b_sx   <= r_a_sx;
            r_b_sz   <= r_a_sz;
            r_b_sr   <= r_a_sr;

            r_s_rem[0]  <= (NW'(r_b_hh_x) << (2 * H)) + (NW'(r_b_hl_x) << (H + 1))
                         + NW'(r_b_ll_x)
                         + (NW'(r_b_hh_z) << (2 * H)) + (NW'(r_b_hl_z) << (H + 1))
                         + NW'(r_b_ll_z);
            r_s_root[0] <= '0;
            r_s_dx[0]   <= r_b_dx;
            r_s_dz[0]   <= r_b_dz;
            r_s_rsum[0] <= r_b_rsum;
            r_s_sx[0]   <= r_b_sx;
            r_s_sz[0]   <= r_b_sz;
            r_s_sr[0]   <= r_b_sr;
        end
    end

    for (genvar k = 0; k < NS; k++) begin : g_sqrt
        localparam int B = W - k;
        logic [NW-1:0] trial;
        logic          take;

        assign trial = (NW'(r_s_root[k]) << (B + 1)) | (NW'(1) << (2 * B));
        assign take  = r_s_rem[k] >= trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_s_vld[k+1] <= 1'b0;
            end else if (en) begin
                r_s_vld[k+1] <= r_s_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_s_rem[k+1]  <= take ? r_s_rem[k] - trial : r_s_rem[k];
                r_s_root[k+1] <= take ? (r_s_root[k] | ((W + 1)'(1) << B)) : r_s_root[k];
                r_s_dx[k+1]   <= r_s_dx[k];
                r_s_dz[k+1]   <= r_s_dz[k];
                r_s_rsum[k+1] <= r_s_rsum[k];
                r_s_sx[k+1]   <= r_s_sx[k];
                r_s_sz[k+1]   <= r_s_sz[k];
                r_s_sr[k+1]   <= r_s_sr[k];
            end
        end
    end

    assign n_depth = (W + 1)'(r_s_rsum[NS]) - r_s_root[NS];
    assign n_neg   = (W + 1)'(r_s_rsum[NS]) < r_s_root[NS];
    assign o_push  = r_s_vld[NS] && !i_q_stat.full && !n_neg;
    assign o_push_data = {r_s_dx[NS], r_s_dz[NS], r_s_root[NS], n_depth[W-1:0],
                          r_s_sx[NS], r_s_sz[NS], r_s_sr[NS]};

endmodule

// ----- hw/rtl/ccc_queue.sv -----
// Short queue of accepted contacts between the front and back parts.
// Depends on ccc_pkg for its depth and status type.
module ccc_queue #(
    parameter int DW = 226
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [DW-1:0]    i_push_data,
    input  logic             i_pop,
    output logic [DW-1:0]    o_head,
    output ccc_pkg::t_q_stat o_stat
);

    localparam int AW = $clog2(ccc_pkg::Q_DEPTH);

    logic [DW-1:0] r_mem [0:ccc_pkg::Q_DEPTH-1];
    logic [AW-1:0] r_wr, r_rd;
    logic [AW:0]   r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + AW'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + AW'(1);
            end
            r_cnt <= r_cnt + (AW + 1)'(i_push) - (AW + 1)'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

    assign o_head       = r_mem[r_rd];
    assign o_stat.full  = r_cnt == (AW + 1)'(ccc_pkg::Q_DEPTH);
    assign o_stat.empty = r_cnt == '0;

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_stat.full) else $error("queue written while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_stat.empty) else $error("queue read while empty");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (AW + 1)'(ccc_pkg::Q_DEPTH)) else $error("queue count out of range");
`endif

endmodule

// ----- hw/rtl/ccc_back.sv -----
// Back part: pipelined normal division, contact offset product, rounding and saturation.
// Depends on ccc_pkg for the normal and quotient widths and the queue status type.
module ccc_back #(
    parameter int W = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic [7*W+1:0]                   i_head,
    input  ccc_pkg::t_q_stat                 i_q_stat,
    output logic                             o_pop,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [ccc_pkg::NORM_BITS-1:0]    o_normal_x,
    output logic [ccc_pkg::NORM_BITS-1:0]    o_normal_z,
    output logic [W-1:0]                     o_contact_x,
    output logic [W-1:0]                     o_contact_z,
    output logic [W-1:0]                     o_depth
);

    localparam int QB = ccc_pkg::QUO_BITS;
    localparam int NB = ccc_pkg::NORM_BITS;
    localparam int RW = W + 17;
    localparam int PW = W + 18;
    localparam int SW = PW + 1;
    localparam logic signed [SW-1:0] MAXV = (SW'(1) <<< (W - 1)) - SW'(1);
    localparam logic signed [SW-1:0] MINV = -MAXV - SW'(1);

    logic signed [W:0] h_dx, h_dz;
    logic [W:0]        h_len;
    logic [W-1:0]      h_depth, h_sx, h_sz;
    logic [W-2:0]      h_sr;
    logic [W:0]        h_mx, h_mz;
    logic              en;

    assign {h_dx, h_dz, h_len, h_depth, h_sx, h_sz, h_sr} = i_head;
    assign h_mx  = h_dx[W] ? -h_dx : h_dx;
    assign h_mz  = h_dz[W] ? -h_dz : h_dz;
    assign en    = !o_out_valid || !i_out_stall;
    assign o_pop = en && !i_q_stat.empty;

    logic          r_d_vld   [0:QB];
    logic [RW-1:0] r_d_rem_x [0:QB];
    logic [RW-1:0] r_d_rem_z [0:QB];
    logic [QB-1:0] r_d_q_x   [0:QB];
    logic [QB-1:0] r_d_q_z   [0:QB];
    logic [W+1:0]  r_d_den   [0:QB];
    logic          r_d_neg_x [0:QB];
    logic          r_d_neg_z [0:QB];
    logic          r_d_zero  [0:QB];
    logic [W-1:0]  r_d_depth [0:QB];
    logic [W-1:0]  r_d_sx    [0:QB];
    logic [W-1:0]  r_d_sz    [0:QB];
    logic [W-2:0]  r_d_sr    [0:QB];

    logic                 r_n_vld;
    logic signed [NB-1:0] r_n_nx, r_n_nz;
    logic signed [W+1:0]  r_n_s2;
    logic [W-1:0]         r_n_depth, r_n_sx, r_n_sz;

    logic                 r_m_vld;
    logic signed [PW-1:0] r_m_px, r_m_pz;
    logic signed [NB-1:0] r_m_nx, r_m_nz;
    logic [W-1:0]         r_m_depth, r_m_sx, r_m_sz;

    logic                 r_o_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld[0] <= 1'b0;
            r_n_vld    <= 1'b0;
            r_m_vld    <= 1'b0;
            r_o_vld    <= 1'b0;
        end else if (en) begin
            r_d_vld[0] <= !i_q_stat.empty;
            r_n_vld    <= r_d_vld[QB];
            r_m_vld    <= r_n_vld;
            r_o_vld    <= r_m_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d_rem_x[0] <= (RW'(h_mx) << QB) + RW'(h_len);
            r_d_rem_z[0] <= (RW'(h_mz) << QB) + RW'(h_len);
            r_d_q_x[0]   <= '0;
            r_d_q_z[0]   <= '0;
            r_d_den[0]   <= {h_len, 1'b0};
            r_d_neg_x[0] <= h_dx[W];
            r_d_neg_z[0] <= h_dz[W];
            r_d_zero[0]  <= h_len == '0;
            r_d_depth[0] <= h_depth;
            r_d_sx[0]    <= h_sx;
            r_d_sz[0]    <= h_sz;
            r_d_sr[0]    <= h_sr;
        end
    end

    for (genvar k = 0; k < QB; k++) begin : g_div
        localparam int I = QB - 1 - k;
        logic [RW-1:0] sub;
        logic          ge_x, ge_z;

        assign sub  = RW'(r_d_den[k]) << I;
        assign ge_x = r_d_rem_x[k] >= sub;
        assign ge_z = r_d_rem_z[k] >= sub;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_d_vld[k+1] <= 1'b0;
            end else if (en) begin
                r_d_vld[k+1] <= r_d_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_d_rem_x[k+1] <= ge_x ? r_d_rem_x[k] - sub : r_d_rem_x[k];
                r_d_rem_z[k+1] <= ge_z ? r_d_rem_z[k] - sub : r_d_rem_z[k];
                r_d_q_x[k+1]   <= r_d_q_x[k] | (QB'(ge_x) << I);
                r_d_q_z[k+1]   <= r_d_q_z[k] | (QB'(ge_z) << I);
                r_d_den[k+1]   <= r_d_den[k];
                r_d_neg_x[k+1] <= r_d_neg_x[k];
                r_d_neg_z[k+1] <= r_d_neg_z[k];
                r_d_zero[k+1]  <= r_d_zero[k];
                r_d_depth[k+1] <= r_d_depth[k];
                r_d_sx[k+1]    <= r_d_sx[k];
                r_d_sz[k+1]    <= r_d_sz[k];
                r_d_sr[k+1]    <= r_d_sr[k];
            end
        end
    end

    logic signed [NB-1:0] n_nx, n_nz;
    logic [PW-1:0]        n_mag_x, n_mag_z;
    logic [PW-1:0]        n_rq_x, n_rq_z;
    logic signed [SW-1:0] n_sum_x, n_sum_z;

    assign n_nx = r_d_zero[QB] ? '0 :
                  r_d_neg_x[QB] ? -$signed(NB'(r_d_q_x[QB])) : $signed(NB'(r_d_q_x[QB]));
    assign n_nz = r_d_zero[QB] ? '0 :
                  r_d_neg_z[QB] ? -$signed(NB'(r_d_q_z[QB])) : $signed(NB'(r_d_q_z[QB]));

    assign n_mag_x = r_m_px[PW-1] ? PW'(-r_m_px) : PW'(r_m_px);
    assign n_mag_z = r_m_pz[PW-1] ? PW'(-r_m_pz) : PW'(r_m_pz);
    assign n_rq_x  = (n_mag_x + (PW'(1) << (QB - 1))) >> QB;
    assign n_rq_z  = (n_mag_z + (PW'(1) << (QB - 1))) >> QB;
    assign n_sum_x = SW'($signed(r_m_sx))
                   + (r_m_px[PW-1] ? -$signed(SW'(n_rq_x)) : $signed(SW'(n_rq_x)));
    assign n_sum_z = SW'($signed(r_m_sz))
                   + (r_m_pz[PW-1] ? -$signed(SW'(n_rq_z)) : $signed(SW'(n_rq_z)));

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_n_nx    <= n_nx;
            r_n_nz    <= n_nz;
            r_n_s2    <= $signed({2'b00, r_d_sr[QB], 1'b0}) - $signed({2'b00, r_d_depth[QB]});
            r_n_depth <= r_d_depth[QB];
            r_n_sx    <= r_d_sx[QB];
            r_n_sz    <= r_d_sz[QB];

            r_m_px    <= PW'(r_n_nx * r_n_s2);
            r_m_pz    <= PW'(r_n_nz * r_n_s2);
            r_m_nx    <= r_n_nx;
            r_m_nz    <= r_n_nz;
            r_m_depth <= r_n_depth;
            r_m_sx    <= r_n_sx;
            r_m_sz    <= r_n_sz;

            o_normal_x  <= r_m_nx;
            o_normal_z  <= r_m_nz;
            o_depth     <= r_m_depth;
            o_contact_x <= (n_sum_x > MAXV) ? W'(MAXV) :
                           (n_sum_x < MINV) ? W'(MINV) : W'(n_sum_x);
            o_contact_z <= (n_sum_z > MAXV) ? W'(MAXV) :
                           (n_sum_z < MINV) ? W'(MINV) : W'(n_sum_z);
        end
    end

    assign o_out_valid = r_o_vld;

endmodule

// ----- hw/rtl/circle_circle_collision.sv -----
// Top level of the circle-circle collision test in the X-Z plane.
// Instantiates ccc_front, ccc_queue and ccc_back; uses ccc_pkg for shared types.
//
//   channel   direction  handshake                   payload
//   input     in         i_in_valid / o_in_stall     self and other centre and radius
//   output    out        o_out_valid / i_out_stall   normal, contact point, depth
//
// One circle pair is accepted per cycle while nothing downstream stalls.
// Front: differences, partial squares and their sum, then a one-bit-per-stage square root.
// The back runs the fifteen-stage normal divider, then the product and the rounded output.
// Reset clears only the valid flags and the queue pointers and count; no clearing pass is needed.
// A stall at the output halts the back, the queue absorbs four contacts, then the front halts.
module circle_circle_collision #(
    parameter int COORD_BITS = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [COORD_BITS-1:0]           i_self_x,
    input  logic [COORD_BITS-1:0]           i_self_z,
    input  logic [COORD_BITS-2:0]           i_self_radius,
    input  logic [COORD_BITS-1:0]           i_other_x,
    input  logic [COORD_BITS-1:0]           i_other_z,
    input  logic [COORD_BITS-2:0]           i_other_radius,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [ccc_pkg::NORM_BITS-1:0]   o_normal_x,
    output logic [ccc_pkg::NORM_BITS-1:0]   o_normal_z,
    output logic [COORD_BITS-1:0]           o_contact_x,
    output logic [COORD_BITS-1:0]           o_contact_z,
    output logic [COORD_BITS-1:0]           o_depth
);

    localparam int DW = 7 * COORD_BITS + 2;

    ccc_pkg::t_q_stat q_stat;
    logic             push, pop;
    logic [DW-1:0]    push_data, head;

    ccc_front #(.W(COORD_BITS)) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_self_x       (i_self_x),
        .i_self_z       (i_self_z),
        .i_self_radius  (i_self_radius),
        .i_other_x      (i_other_x),
        .i_other_z      (i_other_z),
        .i_other_radius (i_other_radius),
        .i_q_stat       (q_stat),
        .o_push         (push),
        .o_push_data    (push_data)
    );

    ccc_queue #(.DW(DW)) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .i_pop       (pop),
        .o_head      (head),
        .o_stat      (q_stat)
    );

    ccc_back #(.W(COORD_BITS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .i_q_stat    (q_stat),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_normal_x  (o_normal_x),
        .o_normal_z  (o_normal_z),
        .o_contact_x (o_contact_x),
        .o_contact_z (o_contact_z),
        .o_depth     (o_depth)
    );

endmodule

// ----- tb/sv/tb_circle_circle_collision.sv -----
// Self-checking testbench for circle_circle_collision: drives circle pairs,
// predicts normal, contact point and depth, and checks every result in order.
// Depends on the circle_circle_collision RTL and ccc_pkg.
module tb_circle_circle_collision;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CB = 32;
    localparam int NB = ccc_pkg::NORM_BITS;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [NB-1:0] normal_x;
        logic [NB-1:0] normal_z;
        logic [CB-1:0] contact_x;
        logic [CB-1:0] contact_z;
        logic [CB-1:0] depth;
    } t_contact;

    logic          i_clk;
    logic          i_rst_n;
    logic          i_in_valid;
    logic          o_in_stall;
    logic [CB-1:0] i_self_x, i_self_z, i_other_x, i_other_z;
    logic [CB-2:0] i_self_radius, i_other_radius;
    logic          o_out_valid;
    logic          i_out_stall;
    logic [NB-1:0] o_normal_x, o_normal_z;
    logic [CB-1:0] o_contact_x, o_contact_z, o_depth;

    t_contact contact_queue[$];
    int       send_idle_pct;
    int       recv_stall_pct;
    bit       failed;
    longint   cycles;

    circle_circle_collision #(.COORD_BITS(CB)) u_dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("circle_circle_collision regression: fail");
            $finish;
        end
    end

    function automatic longint round_div(longint num, longint den);
        longint m;
        longint q;
        m = (num < 0) ? -num : num;
        q = (m * 2 + den) / (den * 2);
        return (num < 0) ? -q : q;
    endfunction

    function automatic longint clamp_coord(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic bit predict_contact(logic [CB-1:0] sx_b, logic [CB-1:0] sz_b,
                                           logic [CB-2:0] sr_b, logic [CB-1:0] ox_b,
                                           logic [CB-1:0] oz_b, logic [CB-2:0] or_b,
                                           output t_contact res);
        longint sx, sz, ox, oz, dx, dz, len, dep, nx, nz, s2, p;
        logic [127:0] dist2, cand;
        sx = longint'($signed(sx_b));
        sz = longint'($signed(sz_b));
        ox = longint'($signed(ox_b));
        oz = longint'($signed(oz_b));
        dx = ox - sx;
        dz = oz - sz;
        dist2 = 128'(dx * dx) + 128'(dz * dz);
        len = 0;
        for (int b = CB + 1; b >= 0; b--) begin
            cand = 128'(len | (64'sd1 <<< b));
            if (cand * cand <= dist2) len = longint'(cand);
        end
        dep = longint'(sr_b) + longint'(or_b) - len;
        if (dep < 0) return 1'b0;
        nx = 0;
        nz = 0;
        if (len != 0) begin
            nx = round_div(dx * 16384, len);
            nz = round_div(dz * 16384, len);
        end
        s2 = 2 * longint'(sr_b) - dep;
        res.normal_x = nx[NB-1:0];
        res.normal_z = nz[NB-1:0];
        p = nx * s2;
        p = (p < 0) ? -((-p + 16384) >>> 15) : ((p + 16384) >>> 15);
        res.contact_x = CB'(clamp_coord(sx + p));
        p = nz * s2;
        p = (p < 0) ? -((-p + 16384) >>> 15) : ((p + 16384) >>> 15);
        res.contact_z = CB'(clamp_coord(sz + p));
        res.depth = dep[CB-1:0];
        return 1'b1;
    endfunction

    // Result checker: compares each accepted transaction with the oldest prediction.
    always @(posedge i_clk) begin
        t_contact exp_c;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (contact_queue.size() == 0) begin
                $error("unexpected result transaction");
                failed = 1'b1;
            end else begin
                exp_c = contact_queue.pop_front();
                if (o_normal_x !== exp_c.normal_x) begin
                    $error("normal_x exp %h got %h", exp_c.normal_x, o_normal_x);
                    failed = 1'b1;
                end
                if (o_normal_z !== exp_c.normal_z) begin
                    $error("normal_z exp %h got %h", exp_c.normal_z, o_normal_z);
                    failed = 1'b1;
                end
                if (o_contact_x !== exp_c.contact_x) begin
                    $error("contact_x exp %h got %h", exp_c.contact_x, o_contact_x);
                    failed = 1'b1;
                end
                if (o_contact_z !== exp_c.contact_z) begin
                    $error("contact_z exp %h got %h", exp_c.contact_z, o_contact_z);
                    failed = 1'b1;
                end
                if (o_depth !== exp_c.depth) begin
                    $error("depth exp %h got %h", exp_c.depth, o_depth);
                    failed = 1'b1;
                end
            end
        end
    end

    always @(negedge i_clk) begin
        i_out_stall <= i_rst_n && ($urandom_range(99) < recv_stall_pct);
    end

    task automatic send_pair(logic [CB-1:0] sx, logic [CB-1:0] sz, logic [CB-2:0] sr,
                             logic [CB-1:0] ox, logic [CB-1:0] oz, logic [CB-2:0] orad);
        t_contact res;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_self_x <= sx;
        i_self_z <= sz;
        i_self_radius <= sr;
        i_other_x <= ox;
        i_other_z <= oz;
        i_other_radius <= orad;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        if (predict_contact(sx, sz, sr, ox, oz, orad, res)) begin
            contact_queue.insert(contact_queue.size(), res);
        end
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (contact_queue.size() != 0) @(negedge i_clk);
        repeat (60) @(negedge i_clk);
    endtask

    task automatic test_directed();
        send_pair(32'h0, 32'h0, 31'h0, 32'h0, 32'h0, 31'h0);
        send_pair(32'h0, 32'h0, 31'h7FFF_FFFF, 32'h0, 32'h0, 31'h7FFF_FFFF);
        send_pair(32'h8000_0000, 32'h8000_0000, 31'h7FFF_FFFF,
                  32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF);
        send_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF,
                  32'h8000_0000, 32'h8000_0000, 31'h7FFF_FFFF);
        send_pair(32'h0, 32'h0, 31'h0001_0000, 32'h0002_0000, 32'h0, 31'h0001_0000);
        send_pair(32'h0, 32'h0, 31'h0001_0000, 32'h0003_0000, 32'h0, 31'h0001_0000);
        send_pair(32'h0, 32'h0, 31'h0001_0000, 32'h0, 32'hFFFF_0000, 31'h0001_0000);
        send_pair(32'h7FFF_0000, 32'h0, 31'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0, 31'h0);
        send_pair(32'h8000_0000, 32'h0, 31'h7FFF_FFFF, 32'h8000_0100, 32'h0, 31'h0);
        send_pair(32'h1234_5678, 32'h8765_4321, 31'h0, 32'h1234_5679, 32'h8765_4322, 31'h1);
        send_pair(32'd5, 32'd7, 31'd3, 32'd8, 32'd11, 31'd2);
        send_pair(32'd0, 32'd0, 31'd0, 32'd3, 32'd4, 31'd4);
        send_pair(32'h0, 32'h0, 31'h0, 32'h0, 32'h7FFF_FFFF, 31'h7FFF_FFFF);
        send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF, 31'h1, 32'h0, 32'h0, 31'h0);
        drain_results();
    endtask

    task automatic test_random(int count);
        logic [CB-1:0] sx, sz, ox, oz;
        logic [CB-2:0] sr, orad;
        for (int n = 0; n < count; n++) begin
            sx = $urandom;
            sz = $urandom;
            sr = 31'($urandom);
            if ($urandom_range(3) != 0) begin
                // Mostly overlapping pairs, so that results are common.
                ox = sx + (($urandom_range(1) != 0) ? ($urandom >> $urandom_range(31)) :
                                                      -($urandom >> $urandom_range(31)));
                oz = sz + (($urandom_range(1) != 0) ? ($urandom >> $urandom_range(31)) :
                                                      -($urandom >> $urandom_range(31)));
                sr = sr >> $urandom_range(30);
                orad = 31'($urandom);
            end else begin
                ox = $urandom;
                oz = $urandom;
                orad = 31'($urandom);
            end
            send_pair(sx, sz, sr, ox, oz, orad);
            if (n == count / 2) drain_results();
        end
        drain_results();
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_out_stall = 1'b0;
        i_self_x = '0;
        i_self_z = '0;
        i_self_radius = '0;
        i_other_x = '0;
        i_other_z = '0;
        i_other_radius = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        failed = 1'b0;
        cycles = 0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_random(250);
        send_idle_pct = 60;
        test_random(250);
        send_idle_pct = 0;
        recv_stall_pct = 60;
        test_random(250);
        send_idle_pct = 14;
        recv_stall_pct = 14;
        test_random(250);
        if (!failed) begin
            $display("circle_circle_collision regression: pass");
        end else begin
            $display("circle_circle_collision regression: fail");
        end
        $finish;
    end
endmodule

// ----- files.f -----
hw/rtl/ccc_pkg.sv
hw/rtl/ccc_front.sv
hw/rtl/ccc_queue.sv
hw/rtl/ccc_back.sv
hw/rtl/circle_circle_collision.sv
tb/sv/tb_circle_circle_collision.sv
